// ===== sv/isort_pkg.sv =====
// Shared constants and controller/datapath command and status types for the integer sorter.
`default_nettype none
package isort_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic insert;    // store the incoming element in order
    logic set_ovf;   // incoming element dropped, store full
    logic shift;     // head element taken, move the rest down
    logic clr_ovf;   // run finished
  } cmd_t;

  typedef struct packed {
    logic             full;
    logic             count_is_one;
    logic [CNT_W-1:0] count;
  } status_t;

endpackage
`default_nettype wire

// ===== sv/isort_if.sv =====
// Valid/ready channel interfaces for the sorter's input and result streams.
`default_nettype none
interface isort_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [isort_pkg::DATA_W-1:0]   element;
  logic                                  last_element;

  modport source (output valid, output element, output last_element, input ready);
  modport sink (input valid, input element, input last_element, output ready);
endinterface

interface isort_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [isort_pkg::DATA_W-1:0]   sorted_element;
  logic                                  last_of_run;
  logic                                  overflow;

  modport source (output valid, output sorted_element, output last_of_run, output overflow,
                  input ready);
  modport sink (input valid, input sorted_element, input last_of_run, input overflow,
                output ready);
endinterface
`default_nettype wire

// ===== sv/integer_sorter_top.sv =====
// Integer sorter top level: channels, controller, datapath and checks.
//
// Usage: signed 32-bit elements arrive on in_if, one per transaction, the final
// element of a block flagged by last_element. Each accepted element is placed
// in order into a row of 16 cells (one comparator per cell), so loading runs
// at one element per cycle. Elements past the 16th are dropped and the run's
// overflow flag is set. In the cycle after the last element is accepted,
// out_if presents the smallest element; each result transaction shifts the
// row down by one cell, so results follow at one per cycle while out_if.ready
// is high. The final result carries last_of_run. in_if.ready is low from the
// last element until the final result is taken.
// A stall on out_if simply holds the current result and the cell row.
// Reset (rst_n low at a clock edge) empties the store, clears the overflow
// flag and drops any pending results; in_if.ready rises the cycle after reset.
`default_nettype none
module integer_sorter_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  isort_in_if.sink   in_if,
  isort_out_if.source out_if
);

  isort_pkg::cmd_t    cmd;
  isort_pkg::status_t status;
  logic signed [isort_pkg::DATA_W-1:0] head;
  logic               ovf;
  logic               in_ready;
  logic               out_valid;

  isort_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_last   (in_if.last_element),
    .out_ready (out_if.ready),
    .status    (status),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  isort_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .element  (in_if.element),
    .status   (status),
    .head     (head),
    .overflow (ovf)
  );

  assign in_if.ready           = in_ready;
  assign out_if.valid          = out_valid;
  assign out_if.sorted_element = head;
  assign out_if.last_of_run    = status.count_is_one;
  assign out_if.overflow       = ovf;

  a_drain_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (status.count != '0))
    else $error("result offered with empty store");

  a_no_overlap : assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("loading and draining at once");

  a_run_end : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_if.ready && status.count_is_one) |=>
      (in_ready && !out_valid && status.count == '0 && !ovf))
    else $error("run end did not return to empty load state");

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    status.count <= isort_pkg::CNT_W'(isort_pkg::CAPACITY))
    else $error("element count beyond capacity");

endmodule
`default_nettype wire

// ===== sv/isort_ctrl.sv =====
// Load/drain controller of the integer sorter.
`default_nettype none
module isort_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_last,
  input  wire logic               out_ready,
  input  wire isort_pkg::status_t status,
  output logic                    in_ready,
  output logic                    out_valid,
  output isort_pkg::cmd_t         cmd
);

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   out_valid_r;
  logic   in_xact;
  logic   out_xact;

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;
  assign in_xact   = in_valid && in_ready_r;
  assign out_xact  = out_valid_r && out_ready;

  always_comb begin
    cmd.insert  = in_xact && !status.full;
    cmd.set_ovf = in_xact && status.full;
    cmd.shift   = out_xact;
    cmd.clr_ovf = out_xact && status.count_is_one;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      in_ready_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_LOAD: begin
          in_ready_r <= 1'b1;
          if (in_xact && in_last) begin
            state_r     <= ST_DRAIN;
            in_ready_r  <= 1'b0;
            out_valid_r <= 1'b1;
          end
        end
        ST_DRAIN: begin
          if (out_xact && status.count_is_one) begin
            state_r     <= ST_LOAD;
            in_ready_r  <= 1'b1;
            out_valid_r <= 1'b0;
          end
        end
        default: begin
          state_r     <= ST_LOAD;
          in_ready_r  <= 1'b0;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/isort_dp.sv =====
// Datapath: row of sorted element cells with per-cell comparators, count and overflow flag.
`default_nettype none
module isort_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire isort_pkg::cmd_t                      cmd,
  input  wire logic signed [isort_pkg::DATA_W-1:0]  element,
  output isort_pkg::status_t                        status,
  output logic signed [isort_pkg::DATA_W-1:0]       head,
  output logic                                      overflow
);

  localparam int CAP   = isort_pkg::CAPACITY;
  localparam int CNT_W = isort_pkg::CNT_W;

  logic signed [isort_pkg::DATA_W-1:0] cell_r   [CAP];
  logic signed [isort_pkg::DATA_W-1:0] cell_nxt [CAP];
  logic [CAP-1:0]   gt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             ovf_r;
  logic             ovf_nxt;

  // Cell i holds a larger value than the new element; monotone over the filled cells.
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      gt[i] = (CNT_W'(i) < count_r) && (element < cell_r[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      cell_nxt[i] = cell_r[i];
    end
    if (cmd.insert) begin
      if (gt[0] || count_r == '0) begin
        cell_nxt[0] = element;
      end
      for (int i = 1; i < CAP; i++) begin
        if (gt[i] || CNT_W'(i) == count_r) begin
          cell_nxt[i] = gt[i-1] ? cell_r[i-1] : element;
        end
      end
    end else if (cmd.shift) begin
      for (int i = 0; i < CAP - 1; i++) begin
        cell_nxt[i] = cell_r[i+1];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.shift) begin
      count_nxt = count_r - CNT_W'(1);
    end
    ovf_nxt = ovf_r;
    if (cmd.set_ovf) begin
      ovf_nxt = 1'b1;
    end else if (cmd.clr_ovf) begin
      ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAP; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  assign status.full         = (count_r == CNT_W'(CAP));
  assign status.count_is_one = (count_r == CNT_W'(1));
  assign status.count        = count_r;
  assign head                = cell_r[0];
  assign overflow            = ovf_r;

endmodule
`default_nettype wire

// ===== bench/sort_order_checker.sv =====
// Watches both sorter channels, predicts each sorted run and compares the results.
`timescale 1ns / 100ps
module sort_order_checker (
  input  logic        clk,
  input  logic        rst_n,
  isort_in_if         in_ch,
  isort_out_if        out_ch,
  output int          fail_count,
  output int          pending_results
);

  typedef struct packed {
    logic signed [isort_pkg::DATA_W-1:0] value;
    logic                                last;
    logic                                ovf;
  } sorted_result_t;

  logic signed [isort_pkg::DATA_W-1:0] held [isort_pkg::CAPACITY];
  int                                  held_count;
  logic                                run_overflow;
  sorted_result_t                      expected_q [$];
  int                                  reports;

  always @(posedge clk) begin
    int             k;
    sorted_result_t want;
    if (!rst_n) begin
      expected_q.delete();
      held_count   = 0;
      run_overflow = 1'b0;
      fail_count   = 0;
      reports      = 0;
    end else begin
      // input transaction: keep the held run in ascending order
      if (in_ch.valid && in_ch.ready) begin
        if (held_count < isort_pkg::CAPACITY) begin
          k = held_count;
          while (k > 0 && in_ch.element < held[k-1]) begin
            held[k] = held[k-1];
            k--;
          end
          held[k] = in_ch.element;
          held_count++;
        end else begin
          run_overflow = 1'b1;
        end
        if (in_ch.last_element) begin
          for (k = 0; k < held_count; k++) begin
            want.value = held[k];
            want.last  = (k + 1 == held_count);
            want.ovf   = run_overflow;
            expected_q.push_back(want);
          end
          held_count   = 0;
          run_overflow = 1'b0;
        end
      end

      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (reports < 10)
            $display("%0t: unexpected result %0d last %0b ovf %0b", $realtime,
                     out_ch.sorted_element, out_ch.last_of_run, out_ch.overflow);
          reports++;
        end else begin
          want = expected_q.pop_front();
          if (out_ch.sorted_element !== want.value || out_ch.last_of_run !== want.last ||
              out_ch.overflow !== want.ovf) begin
            fail_count++;
            if (reports < 10)
              $display("%0t: mismatch: expected %0d last %0b ovf %0b, got %0d last %0b ovf %0b",
                       $realtime, want.value, want.last, want.ovf, out_ch.sorted_element,
                       out_ch.last_of_run, out_ch.overflow);
            reports++;
          end
        end
      end
    end
    pending_results = expected_q.size();
  end

endmodule

// ===== bench/tb_integer_sorter_top.sv =====
// Top-level bench for the integer sorter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_integer_sorter_top;

  localparam int HOLD_CYCLES  = 200;
  localparam int PHASE_ITEMS  = 50;
  localparam int SETTLE       = 2 * isort_pkg::CAPACITY + 8;

  typedef enum int { VAL_FULL, VAL_NARROW, VAL_EDGES } value_mix_t;

  logic clk = 1'b0;
  logic rst_n;

  isort_in_if  in_ch ();
  isort_out_if out_ch ();

  int fail_count;
  int pending_results;

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  bit hold_req      = 1'b0;

  int items_sent      = 0;
  int blocks_sent     = 0;
  int overflow_blocks = 0;
  int run_len         = 0;

  integer_sorter_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  sort_order_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          out_ch.ready <= 1'b0;
          @(posedge clk);
        end
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
        @(posedge clk);
      end
    end
  end

  function automatic logic signed [isort_pkg::DATA_W-1:0] pick_element(input value_mix_t mix);
    case (mix)
      VAL_NARROW: pick_element = int'($urandom_range(8)) - 4;
      VAL_EDGES: begin
        case ($urandom_range(3))
          0:       pick_element = 32'sh8000_0000;
          1:       pick_element = 32'sh7fff_ffff;
          2:       pick_element = '0;
          default: pick_element = -32'sd1;
        endcase
      end
      default:   pick_element = $urandom();
    endcase
  endfunction

  task automatic send_item(input logic signed [isort_pkg::DATA_W-1:0] value,
                           input logic mark_last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.element      <= value;
    in_ch.last_element <= mark_last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    run_len++;
    if (mark_last) begin
      blocks_sent++;
      if (run_len > isort_pkg::CAPACITY) overflow_blocks++;
      run_len = 0;
    end
  endtask

  task automatic send_block(input int len, input value_mix_t mix);
    for (int i = 0; i < len; i++)
      send_item(pick_element(mix), i == len - 1);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    int start;
    int len;
    int pick;
    start         = items_sent;
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    while (items_sent - start < PHASE_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 10)      len = 1;
      else if (pick < 22) len = isort_pkg::CAPACITY;
      else if (pick < 34) len = $urandom_range(isort_pkg::CAPACITY + 6,
                                               isort_pkg::CAPACITY + 1);
      else                len = $urandom_range(isort_pkg::CAPACITY - 1, 2);
      send_block(len, value_mix_t'($urandom_range(2)));
    end
    wait_drained();
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.element      = '0;
    in_ch.last_element = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-element run, then the signed extremes out of order
    send_item(32'sh7fff_ffff, 1'b1);
    send_item(32'sh7fff_ffff, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sd0, 1'b1);
    // duplicates
    send_item(32'sd5, 1'b0);
    send_item(-32'sd5, 1'b0);
    send_item(32'sd5, 1'b1);
    // store full, and the marked-last element itself dropped
    for (int i = 0; i < isort_pkg::CAPACITY; i++)
      send_item(32'sd1000 - 32'sd97 * i, 1'b0);
    send_item(32'sh8000_0000, 1'b1);
    wait_drained();

    run_phase(0, 0);
    run_phase(45, 0);
    run_phase(0, 45);
    run_phase(31, 31);

    // results held off: the second block must stall at the input
    in_idle_pct   = 0;
    out_stall_pct = 0;
    hold_req      = 1'b1;
    send_block(isort_pkg::CAPACITY + 4, VAL_FULL);
    send_block(6, VAL_NARROW);
    wait_drained();

    repeat (SETTLE) @(posedge clk);
    $display("Sorted %0d blocks from %0d elements; %0d blocks overflowed the store.",
             blocks_sent, items_sent, overflow_blocks);
    $display("Ran free-flow, idle, stall and mixed phases plus a %0d-cycle output hold.",
             HOLD_CYCLES);
    if (fail_count == 0 && pending_results == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d failures, %0d results never seen", fail_count, pending_results);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/isort_pkg.sv
sv/isort_if.sv
sv/isort_ctrl.sv
sv/isort_dp.sv
sv/integer_sorter_top.sv
bench/sort_order_checker.sv
bench/tb_integer_sorter_top.sv
